[sv/swt_pkg.sv]
// shared types, codes and constants for the sequence window tracker
package swt_pkg;

	localparam int SEQ_W     = 8;
	localparam int SIZE_W    = 16;
	localparam int MAP_W     = 128;
	localparam int CNT_W     = $clog2(MAP_W + 1);
	localparam int WINDOW_DF = 128;

	localparam logic [SIZE_W-1:0] PAYLOAD_LIMIT_RST = 16'hFFFF;
	localparam logic [SEQ_W-1:0]  SEQ_ALL_ONES      = 8'hFF;

	typedef enum logic [1:0] {
		CMD_ENQ  = 2'd0,
		CMD_HDR  = 2'd1,
		CMD_DLV  = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_BIG   = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

endpackage

[sv/seq_window_tracker_core.sv]
// top level: input register, send, header and deliver bookkeeping, result register
// throughput: one item per cycle while out_stall is low, set by the single compute
// stage between the registers
// in_stall rises only while a result waits under out_stall and a second item is held
// reset sets the sequence state to its start values, clears the future bitmap
// and sets payload_limit to 65535
module seq_window_tracker_core #(
	parameter int WINDOW = swt_pkg::WINDOW_DF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [swt_pkg::SIZE_W-1:0]  cfg_wr_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  cmd,
	input  logic [swt_pkg::SIZE_W-1:0]  payload_size,
	input  logic [swt_pkg::SEQ_W-1:0]   peer_seqno,
	input  logic [swt_pkg::SEQ_W-1:0]   peer_ack,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [1:0]                  status,
	output logic [swt_pkg::SEQ_W-1:0]   seqno,
	output logic [swt_pkg::SEQ_W-1:0]   ack_to_send,
	output logic [swt_pkg::SEQ_W-1:0]   acked_seqno
);

	localparam int SW = swt_pkg::SEQ_W;

	logic                       valid_s1;
	swt_pkg::cmd_t              cmd_s1;
	logic [swt_pkg::SIZE_W-1:0] size_s1;
	logic [SW-1:0]              peer_seqno_s1;
	logic [SW-1:0]              peer_ack_s1;

	logic [swt_pkg::SIZE_W-1:0] payload_limit_q;
	logic [SW-1:0]              next_send_q;
	logic [SW-1:0]              peer_acked_q;
	logic [SW-1:0]              delivered_q;

	logic                       out_valid_q;
	swt_pkg::status_t           status_q;
	logic [SW-1:0]              seqno_q;
	logic [SW-1:0]              ack_to_send_q;
	logic [SW-1:0]              acked_seqno_q;

	logic                       adv;
	logic                       in_xfer;
	logic                       hdr_upd;
	logic [SW-1:0]              expected_nxt;
	logic [SW-1:0]              expected_cur;
	swt_pkg::status_t           status_c;
	logic [SW-1:0]              seqno_c;
	logic [SW-1:0]              next_send_c;
	logic [SW-1:0]              peer_acked_c;
	logic [SW-1:0]              delivered_c;

	assign adv      = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && out_valid_q && out_stall;
	assign in_xfer  = in_valid && !in_stall;
	assign hdr_upd  = adv && (cmd_s1 == swt_pkg::CMD_HDR);

	swt_rx_window #(
		.WINDOW(WINDOW)
	) u_rx (
		.clk         (clk),
		.arst_n      (arst_n),
		.upd         (hdr_upd),
		.peer_seqno  (peer_seqno_s1),
		.expected_nxt(expected_nxt)
	);

	// current expected seqno for deliver commands, for which upd is low
	assign expected_cur = expected_nxt;

	always_comb begin
		status_c     = swt_pkg::ST_OK;
		seqno_c      = '0;
		next_send_c  = next_send_q;
		peer_acked_c = peer_acked_q;
		delivered_c  = delivered_q;
		case (cmd_s1)
			swt_pkg::CMD_ENQ: begin
				if (peer_acked_q == SW'(next_send_q - SW'(WINDOW))) begin
					status_c = swt_pkg::ST_FULL;
				end else if (size_s1 > payload_limit_q) begin
					status_c = swt_pkg::ST_BIG;
				end else begin
					seqno_c     = next_send_q;
					next_send_c = SW'(next_send_q + SW'(1));
				end
			end
			swt_pkg::CMD_HDR: begin
				peer_acked_c = SW'(peer_ack_s1 - SW'(1));
			end
			swt_pkg::CMD_DLV: begin
				if (SW'(delivered_q + SW'(1)) == expected_cur) begin
					status_c = swt_pkg::ST_EMPTY;
				end else begin
					delivered_c = SW'(delivered_q + SW'(1));
					seqno_c     = delivered_c;
				end
			end
			default: begin
			end
		endcase
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cmd_s1        <= swt_pkg::cmd_t'(cmd);
			size_s1       <= payload_size;
			peer_seqno_s1 <= peer_seqno;
			peer_ack_s1   <= peer_ack;
		end
	end

	// bookkeeping state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			payload_limit_q <= swt_pkg::PAYLOAD_LIMIT_RST;
			next_send_q     <= '0;
			peer_acked_q    <= swt_pkg::SEQ_ALL_ONES;
			delivered_q     <= swt_pkg::SEQ_ALL_ONES;
		end else begin
			if (cfg_wr_en) begin
				payload_limit_q <= cfg_wr_data;
			end
			if (adv) begin
				next_send_q  <= next_send_c;
				peer_acked_q <= peer_acked_c;
				delivered_q  <= delivered_c;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			status_q      <= status_c;
			seqno_q       <= seqno_c;
			ack_to_send_q <= expected_nxt;
			acked_seqno_q <= peer_acked_c;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign seqno       = seqno_q;
	assign ack_to_send = ack_to_send_q;
	assign acked_seqno = acked_seqno_q;

endmodule

[sv/swt_rx_window.sv]
// receive side: future seqno bitmap and expected seqno with in-order advance
module swt_rx_window #(
	parameter int WINDOW = swt_pkg::WINDOW_DF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       upd,
	input  logic [swt_pkg::SEQ_W-1:0]  peer_seqno,
	output logic [swt_pkg::SEQ_W-1:0]  expected_nxt
);

	localparam int MW = swt_pkg::MAP_W;
	localparam int CW = swt_pkg::CNT_W;

	logic [MW-1:0]             map_q;
	logic [swt_pkg::SEQ_W-1:0] expected_q;
	logic [swt_pkg::SEQ_W-1:0] seq_off;
	logic                      in_win;
	logic [MW-1:0]             map_set;
	logic [MW-1:0]             low_zero;
	logic [CW-1:0]             enc;
	logic [CW-1:0]             run_len;
	logic [MW-1:0]             map_nxt;
	logic [swt_pkg::SEQ_W-1:0] exp_adv;

	assign seq_off = swt_pkg::SEQ_W'(peer_seqno - expected_q);
	assign in_win  = {1'b0, seq_off} < (swt_pkg::SEQ_W + 1)'(WINDOW);
	assign map_set = map_q | (in_win ? (MW'(1) << seq_off) : '0);

	// isolate the lowest clear bit; all ones gives zero
	assign low_zero = ~map_set & (map_set + MW'(1));

	always_comb begin
		enc = '0;
		for (int i = 0; i < MW; i++) begin
			if (low_zero[i]) begin
				enc = enc | CW'(i);
			end
		end
	end

	assign run_len = (low_zero == '0) ? CW'(MW) : enc;
	assign map_nxt = map_set >> run_len;
	assign exp_adv = swt_pkg::SEQ_W'(expected_q + swt_pkg::SEQ_W'(run_len));

	assign expected_nxt = upd ? exp_adv : expected_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_q      <= '0;
			expected_q <= '0;
		end else if (upd) begin
			map_q      <= map_nxt;
			expected_q <= exp_adv;
		end
	end

endmodule

[sv/swt_checker.sv]
// port-level checks for the sequence window tracker, bound to the top level
module swt_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_stall,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [1:0]                 status,
	input logic [swt_pkg::SEQ_W-1:0]  seqno,
	input logic [swt_pkg::SEQ_W-1:0]  ack_to_send,
	input logic [swt_pkg::SEQ_W-1:0]  acked_seqno
);

	// a held result keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(seqno)
			&& $stable(ack_to_send) && $stable(acked_seqno))
		else $error("result changed while stalled");

	// refused or empty results carry seqno zero
	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != swt_pkg::ST_OK |-> seqno == '0)
		else $error("refused result with nonzero seqno");

	// the input side only backs up behind a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output back pressure");

	// nothing is offered right after reset
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> !out_valid && !in_stall)
		else $error("activity right after reset");

endmodule

bind seq_window_tracker_core swt_checker u_swt_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.status     (status),
	.seqno      (seqno),
	.ack_to_send(ack_to_send),
	.acked_seqno(acked_seqno)
);

[tb/sv/seq_window_tracker_core_test.sv]
// self-checking testbench for seq_window_tracker_core with a tracking predictor
module seq_window_tracker_core_test;
	import swt_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_HOLD   = 80;

	typedef struct {
		status_t          st;
		logic [SEQ_W-1:0] seq;
		logic [SEQ_W-1:0] ack;
		logic [SEQ_W-1:0] acked;
	} result_t;

	logic              clk;
	logic              arst_n       = 1'b0;
	logic              cfg_wr_en    = 1'b0;
	logic [SIZE_W-1:0] cfg_wr_data  = '0;
	logic              in_valid     = 1'b0;
	logic              in_stall;
	logic [1:0]        cmd          = CMD_NONE;
	logic [SIZE_W-1:0] payload_size = '0;
	logic [SEQ_W-1:0]  peer_seqno   = '0;
	logic [SEQ_W-1:0]  peer_ack     = '0;
	logic              out_valid;
	logic              out_stall    = 1'b0;
	logic [1:0]        status;
	logic [SEQ_W-1:0]  seqno;
	logic [SEQ_W-1:0]  ack_to_send;
	logic [SEQ_W-1:0]  acked_seqno;

	// tracker state mirrored by the predictor
	logic [SEQ_W-1:0]  trk_next_send;
	logic [SEQ_W-1:0]  trk_peer_acked;
	logic [SEQ_W-1:0]  trk_expected;
	logic [SEQ_W-1:0]  trk_delivered;
	logic [MAP_W-1:0]  trk_map;
	logic [SIZE_W-1:0] trk_limit;

	result_t pending_results[$];
	int      fail_count  = 0;
	int      cycle_count = 0;
	bit      idle_on     = 1'b0;
	bit      long_hold_req = 1'b0;
	int      stall_left  = 0;

	seq_window_tracker_core u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.payload_size(payload_size),
		.peer_seqno  (peer_seqno),
		.peer_ack    (peer_ack),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.seqno       (seqno),
		.ack_to_send (ack_to_send),
		.acked_seqno (acked_seqno)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic void tracker_reset();
		trk_next_send  = '0;
		trk_peer_acked = SEQ_ALL_ONES;
		trk_expected   = '0;
		trk_delivered  = SEQ_ALL_ONES;
		trk_map        = '0;
		trk_limit      = PAYLOAD_LIMIT_RST;
	endfunction

	function automatic result_t track_step(cmd_t c, logic [SIZE_W-1:0] size,
			logic [SEQ_W-1:0] pseq, logic [SEQ_W-1:0] pack);
		result_t          r;
		logic [SEQ_W-1:0] offset;
		logic [SEQ_W-1:0] window_base;
		r.st  = ST_OK;
		r.seq = '0;
		window_base = trk_next_send - 8'(WINDOW_DF);
		case (c)
			CMD_ENQ: begin
				if (trk_peer_acked == window_base)
					r.st = ST_FULL;
				else if (size > trk_limit)
					r.st = ST_BIG;
				else begin
					r.seq = trk_next_send;
					trk_next_send = trk_next_send + 8'd1;
				end
			end
			CMD_HDR: begin
				trk_peer_acked = pack - 8'd1;
				offset = pseq - trk_expected;
				if (offset < WINDOW_DF)
					trk_map[offset] = 1'b1;
				while (trk_map[0]) begin
					trk_expected = trk_expected + 8'd1;
					trk_map = trk_map >> 1;
				end
			end
			CMD_DLV: begin
				if (trk_delivered + 8'd1 == trk_expected)
					r.st = ST_EMPTY;
				else begin
					trk_delivered = trk_delivered + 8'd1;
					r.seq = trk_delivered;
				end
			end
			default: begin
			end
		endcase
		r.ack   = trk_expected;
		r.acked = trk_peer_acked;
		return r;
	endfunction

	// result checker
	always @(posedge clk) begin
		result_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: status %0d seqno %0d", status, seqno);
				fail_count++;
			end else begin
				exp_r = pending_results.pop_front();
				if (status !== exp_r.st) begin
					$error("status: expected %0d, actual %0d", exp_r.st, status);
					fail_count++;
				end
				if (seqno !== exp_r.seq) begin
					$error("seqno: expected %0d, actual %0d", exp_r.seq, seqno);
					fail_count++;
				end
				if (ack_to_send !== exp_r.ack) begin
					$error("ack_to_send: expected %0d, actual %0d", exp_r.ack, ack_to_send);
					fail_count++;
				end
				if (acked_seqno !== exp_r.acked) begin
					$error("acked_seqno: expected %0d, actual %0d", exp_r.acked, acked_seqno);
					fail_count++;
				end
			end
		end
	end

	// receiver: random stall bursts plus one long hold on request
	initial begin
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				stall_left = LONG_HOLD;
			end
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				out_stall <= 1'b1;
				stall_left = $urandom_range(0, 3);
			end else
				out_stall <= 1'b0;
		end
	end

	task automatic send_item(cmd_t c, logic [SIZE_W-1:0] size, logic [SEQ_W-1:0] pseq,
			logic [SEQ_W-1:0] pack);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid     <= 1'b1;
		cmd          <= c;
		payload_size <= size;
		peer_seqno   <= pseq;
		peer_ack     <= pack;
		do
			@(posedge clk);
		while (in_stall);
		pending_results.push_back(track_step(c, size, pseq, pack));
	endtask

	task automatic wait_all_results();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_results.size() != 0);
		repeat (3) @(posedge clk);
	endtask

	task automatic set_payload_limit(logic [SIZE_W-1:0] value);
		wait_all_results();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		trk_limit = value;
	endtask

	function automatic logic [SEQ_W-1:0] pick_ack();
		logic [SEQ_W-1:0] outstanding;
		outstanding = trk_next_send - trk_peer_acked - 8'd1;
		if ($urandom_range(0, 99) < 85)
			return trk_peer_acked + 8'd1 + 8'($urandom_range(0, outstanding));
		return 8'($urandom);
	endfunction

	function automatic logic [SEQ_W-1:0] pick_peer_seqno();
		int r;
		r = $urandom_range(0, 9);
		if (r < 7)
			return trk_expected + 8'($urandom_range(0, 7));
		else if (r == 7)
			return trk_expected - 8'($urandom_range(1, 20));
		else if (r == 8)
			return trk_expected + 8'($urandom_range(100, 140));
		return 8'($urandom);
	endfunction

	// headers for a run of seqnos from the expected one, in shuffled order, head last if head_last
	task automatic send_block(int len, bit head_last);
		int               offs[MAP_W];
		int               j;
		int               tmp;
		logic [SEQ_W-1:0] base;
		base = trk_expected;
		for (int i = 0; i < len; i++)
			offs[i] = i;
		for (int i = len - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = offs[i];
			offs[i] = offs[j];
			offs[j] = tmp;
		end
		if (head_last)
			for (int i = 0; i < len - 1; i++)
				if (offs[i] == 0) begin
					offs[i] = offs[len-1];
					offs[len-1] = 0;
				end
		for (int i = 0; i < len; i++)
			send_item(CMD_HDR, 16'($urandom), base + 8'(offs[i]), pick_ack());
	endtask

	task automatic run_traffic(int n);
		int               k;
		int               pick;
		int               blk_len;
		logic [SIZE_W-1:0] size;
		k = 0;
		while (k < n) begin
			pick = $urandom_range(0, 99);
			if (pick < 4) begin
				blk_len = $urandom_range(2, 16);
				send_block(blk_len, 1'b0);
				k += blk_len;
			end else begin
				if (pick < 36) begin
					if ($urandom_range(0, 9) == 0)
						size = 16'($urandom);
					else
						size = 16'($urandom_range(0, trk_limit));
					send_item(CMD_ENQ, size, 8'($urandom), 8'($urandom));
				end else if (pick < 66)
					send_item(CMD_HDR, 16'($urandom), pick_peer_seqno(), pick_ack());
				else if (pick < 92)
					send_item(CMD_DLV, 16'($urandom), 8'($urandom), 8'($urandom));
				else
					send_item(cmd_t'($urandom_range(0, 3)), 16'($urandom), 8'($urandom),
						8'($urandom));
				k++;
			end
		end
	endtask

	task automatic test_directed();
		send_item(CMD_DLV, 16'h0000, 8'h00, 8'h00);
		send_item(CMD_NONE, 16'hFFFF, 8'hFF, 8'hFF);
		send_item(CMD_ENQ, 16'hFFFF, 8'hFF, 8'hFF);
		send_item(CMD_ENQ, 16'h0000, 8'h00, 8'h00);
		send_item(CMD_HDR, 16'h0000, 8'h00, 8'h00);
		send_item(CMD_HDR, 16'hFFFF, trk_expected + 8'd127, 8'hFF);
		send_item(CMD_HDR, 16'h0000, trk_expected + 8'd128, 8'h02);
		send_item(CMD_HDR, 16'h0000, trk_expected - 8'd1, 8'h02);
		send_item(CMD_DLV, 16'h0000, 8'h00, 8'h00);
		send_item(CMD_DLV, 16'h0000, 8'h00, 8'h00);
		send_item(CMD_HDR, 16'h0000, trk_expected + 8'd2, 8'h01);
		send_item(CMD_HDR, 16'h0000, trk_expected + 8'd1, 8'h01);
		send_item(CMD_HDR, 16'h0000, trk_expected, 8'h01);
		repeat (4) send_item(CMD_DLV, 16'h0000, 8'h00, 8'h00);
	endtask

	task automatic test_payload_limit();
		set_payload_limit(16'h0000);
		send_item(CMD_ENQ, 16'h0000, 8'h00, 8'h00);
		send_item(CMD_ENQ, 16'h0001, 8'h00, 8'h00);
		send_item(CMD_ENQ, 16'hFFFF, 8'h00, 8'h00);
		set_payload_limit(16'd1000);
		send_item(CMD_ENQ, 16'd1000, 8'h00, 8'h00);
		send_item(CMD_ENQ, 16'd1001, 8'h00, 8'h00);
		set_payload_limit(16'hFFFF);
		send_item(CMD_ENQ, 16'hFFFF, 8'h00, 8'h00);
	endtask

	// all 128 map entries set at once, the head seqno arrives last
	task automatic test_full_map();
		idle_on = 1'b1;
		send_block(MAP_W, 1'b1);
		send_item(CMD_DLV, 16'h0000, 8'h00, 8'h00);
	endtask

	task automatic test_window_full();
		logic [SEQ_W-1:0] base;
		base = trk_next_send - 8'(WINDOW_DF);
		while (trk_peer_acked != base) begin
			send_item(CMD_ENQ, 16'($urandom), 8'($urandom), 8'($urandom));
			base = trk_next_send - 8'(WINDOW_DF);
		end
		send_item(CMD_ENQ, 16'h0000, 8'h00, 8'h00);
		set_payload_limit(16'h0000);
		send_item(CMD_ENQ, 16'h0005, 8'h00, 8'h00);
		send_item(CMD_HDR, 16'h0000, trk_expected - 8'd1, trk_next_send);
		send_item(CMD_ENQ, 16'h0005, 8'h00, 8'h00);
		send_item(CMD_ENQ, 16'h0000, 8'h00, 8'h00);
		set_payload_limit(16'hFFFF);
	endtask

	task automatic test_backpressure();
		wait_all_results();
		idle_on = 1'b0;
		long_hold_req = 1'b1;
		run_traffic(40);
		wait_all_results();
		idle_on = 1'b1;
	endtask

	task automatic test_random_traffic();
		idle_on = 1'b1;
		set_payload_limit(16'($urandom));
		run_traffic(150);
		set_payload_limit(16'd1024);
		idle_on = 1'b0;
		run_traffic(80);
		idle_on = 1'b1;
		run_traffic(150);
		set_payload_limit(16'hFFFF);
		run_traffic(150);
		idle_on = 1'b0;
		run_traffic(100);
	endtask

	initial begin
		tracker_reset();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_payload_limit();
		test_full_map();
		test_window_full();
		test_backpressure();
		test_random_traffic();
		wait_all_results();
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
